/* rtl/fjrr_pkg.sv */
// shared types and constants for the frame jitter ring
`default_nettype none

package fjrr_pkg;

    // register field widths and reset values
    localparam int CFG_SLOT_W     = 6;
    localparam int CFG_LEN_W      = 9;
    localparam int RST_SLOT_COUNT = 32;
    localparam int RST_FRAME_LEN  = 160;

    // payload widths of the ports
    localparam int SAMPLE_IO_W = 16;
    localparam int SLOT_OUT_W  = 5;

    // register bus
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from the word address
    typedef enum logic
    {
        REG_SLOT_COUNT   = 1'b0,
        REG_FRAME_LENGTH = 1'b1
    } reg_index_t;

    // one accepted input beat
    typedef struct packed
    {
        logic                          func;
        logic signed [SAMPLE_IO_W-1:0] sample;
        logic                          silent;
    } item_t;

    // function codes of the func field
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

endpackage

`default_nettype wire

/* rtl/frame_jitter_ring_recenter.sv */
// frame jitter ring: slot/offset pointers, recentering, frame store and register port
// an accepted beat is held in the input stage register until the output stage can take it
// throughput: one beat per cycle unless stalled; single-port frame store, one access per beat
// reset: pointers, marks and registers return to their reset values, then a clearing
// pass writes zero to every store entry, one per cycle; in_stall stays high during it,
// and register writes are still taken
`default_nettype none

module frame_jitter_ring_recenter
    import fjrr_pkg::*;
#(
    parameter int MAX_SLOTS    = 32,
    parameter int FRAME_MAX    = 256,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [PADDR_W-1:0]            paddr,
    input  wire logic [PDATA_W-1:0]            pwdata,
    output logic      [PDATA_W-1:0]            prdata,
    output logic                               pready,

    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          func,
    input  wire logic signed [SAMPLE_IO_W-1:0] sample_in,
    input  wire logic                          silent,

    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_IO_W-1:0]      sample_out,
    output logic                               overflow_seen,
    output logic                               underflow_seen,
    output logic                               frame_done,
    output logic      [SLOT_OUT_W-1:0]         slot_used
);

    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int OFF_W   = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int LEN_W   = OFF_W + 1;
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int RST_EFF = (RST_SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : RST_SLOT_COUNT;
    localparam int RST_WS  = RST_EFF / 2;

    // configuration registers
    logic [CFG_SLOT_W-1:0] slot_count_reg;
    logic [CFG_LEN_W-1:0]  frame_length_reg;
    reg_index_t            wr_index;

    // pointer state
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [OFF_W-1:0]  write_offset_reg, write_offset_next;
    logic [OFF_W-1:0]  read_offset_reg, read_offset_next;
    logic [SLOT_W-1:0] overflow_mark_reg, overflow_mark_next;
    logic [SLOT_W-1:0] underflow_mark_reg, underflow_mark_next;

    // clearing pass
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // input stage
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // output stage
    logic                           out_valid_reg;
    logic                           out_read_reg;
    logic                           ovf_reg;
    logic                           unf_reg;
    logic                           done_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic signed [SAMPLE_WIDTH-1:0] rdata_reg;

    // frame store
    logic signed [SAMPLE_WIDTH-1:0] frame_mem [DEPTH];
    logic                           mem_we;
    logic                           mem_re;
    logic [ADDR_W-1:0]              mem_addr;
    logic signed [SAMPLE_WIDTH-1:0] mem_wdata;

    // per-beat results
    logic              advance;
    logic              fire;
    logic              accept;
    logic              cfg_write;
    logic              ovf_c;
    logic              unf_c;
    logic              done_c;
    logic [SLOT_W-1:0] slot_c;
    logic [ADDR_W-1:0] item_addr;

    // handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = clear_busy_reg || (s1_valid_reg && !advance);
    assign accept   = in_valid && !in_stall;

    // register port
    assign pready    = 1'b1;
    assign wr_index  = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (wr_index)
            REG_SLOT_COUNT:   prdata = PDATA_W'(slot_count_reg);
            REG_FRAME_LENGTH: prdata = PDATA_W'(frame_length_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg   <= CFG_SLOT_W'(RST_SLOT_COUNT);
            frame_length_reg <= CFG_LEN_W'(RST_FRAME_LEN);
        end
        else if (cfg_write)
        begin
            case (wr_index)
                REG_SLOT_COUNT:   slot_count_reg   <= pwdata[CFG_SLOT_W-1:0];
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[CFG_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // pointer logic for the beat in the input stage
    always_comb
    begin
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  half;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] ws;
        logic [SLOT_W-1:0] rs;
        logic [OFF_W-1:0]  wo;
        logic [OFF_W-1:0]  ro;
        logic [CNT_W-1:0]  slot_sum;
        logic [CNT_W-1:0]  slot_inc;
        logic [LEN_W-1:0]  off_inc;

        // effective slot count and frame length
        if (slot_count_reg < CFG_SLOT_W'(2))
            n = CNT_W'(2);
        else if (32'(slot_count_reg) > 32'(MAX_SLOTS))
            n = CNT_W'(MAX_SLOTS);
        else
            n = CNT_W'(slot_count_reg);
        half = n >> 1;

        if (frame_length_reg == '0)
            len = LEN_W'(1);
        else if (32'(frame_length_reg) > 32'(FRAME_MAX))
            len = LEN_W'(FRAME_MAX);
        else
            len = LEN_W'(frame_length_reg);

        // stale pointers fold back to zero
        ws = ({1'b0, write_slot_reg} >= n) ? '0 : write_slot_reg;
        rs = ({1'b0, read_slot_reg} >= n) ? '0 : read_slot_reg;
        wo = ({1'b0, write_offset_reg} >= len) ? '0 : write_offset_reg;
        ro = ({1'b0, read_offset_reg} >= len) ? '0 : read_offset_reg;

        write_slot_next     = ws;
        read_slot_next      = rs;
        write_offset_next   = wo;
        read_offset_next    = ro;
        overflow_mark_next  = overflow_mark_reg;
        underflow_mark_next = underflow_mark_reg;
        ovf_c               = 1'b0;
        unf_c               = 1'b0;
        done_c              = 1'b0;
        slot_sum            = '0;
        slot_inc            = '0;
        off_inc             = '0;

        if (s1_item_reg.func == FUNC_WRITE)
        begin
            // overflow: put the writer half a ring ahead of the reader
            if (wo == '0 && ws == rs)
            begin
                if (rs != overflow_mark_reg)
                begin
                    overflow_mark_next = rs;
                    ovf_c              = 1'b1;
                end
                slot_sum = {1'b0, rs} + half;
                if (slot_sum >= n)
                    slot_sum = slot_sum - n;
                ws = slot_sum[SLOT_W-1:0];
            end
            slot_c    = ws;
            item_addr = {ws, wo};
            off_inc   = {1'b0, wo} + LEN_W'(1);
            if (off_inc >= len)
            begin
                write_offset_next = '0;
                slot_inc          = {1'b0, ws} + CNT_W'(1);
                write_slot_next   = (slot_inc >= n) ? '0 : slot_inc[SLOT_W-1:0];
                done_c            = 1'b1;
            end
            else
            begin
                write_offset_next = off_inc[OFF_W-1:0];
                write_slot_next   = ws;
            end
        end
        else
        begin
            // underflow: put the reader half a ring behind the writer
            if (ro == '0 && rs == ws)
            begin
                if (ws != underflow_mark_reg)
                begin
                    underflow_mark_next = ws;
                    unf_c               = 1'b1;
                end
                slot_sum = {1'b0, ws} + (n - half);
                if (slot_sum >= n)
                    slot_sum = slot_sum - n;
                rs = slot_sum[SLOT_W-1:0];
            end
            slot_c    = rs;
            item_addr = {rs, ro};
            off_inc   = {1'b0, ro} + LEN_W'(1);
            if (off_inc >= len)
            begin
                read_offset_next = '0;
                slot_inc         = {1'b0, rs} + CNT_W'(1);
                read_slot_next   = (slot_inc >= n) ? '0 : slot_inc[SLOT_W-1:0];
                done_c           = 1'b1;
            end
            else
            begin
                read_offset_next = off_inc[OFF_W-1:0];
                read_slot_next   = rs;
            end
        end
    end

    // store access: clearing pass first, then one access per beat
    assign mem_we    = clear_busy_reg || (fire && s1_item_reg.func == FUNC_WRITE);
    assign mem_re    = fire && s1_item_reg.func == FUNC_READ;
    assign mem_addr  = clear_busy_reg ? clear_addr_reg : item_addr;
    assign mem_wdata = (clear_busy_reg || s1_item_reg.silent) ? '0
                     : SAMPLE_WIDTH'(s1_item_reg.sample);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= frame_mem[mem_addr];
    end

    // clearing pass sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(DEPTH - 1))
                clear_busy_reg <= 1'b0;
        end
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg     <= SLOT_W'(RST_WS);
            read_slot_reg      <= '0;
            write_offset_reg   <= '0;
            read_offset_reg    <= '0;
            overflow_mark_reg  <= '0;
            underflow_mark_reg <= '0;
        end
        else if (fire)
        begin
            write_slot_reg     <= write_slot_next;
            read_slot_reg      <= read_slot_next;
            write_offset_reg   <= write_offset_next;
            read_offset_reg    <= read_offset_next;
            overflow_mark_reg  <= overflow_mark_next;
            underflow_mark_reg <= underflow_mark_next;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.func   <= func;
            s1_item_reg.sample <= sample_in;
            s1_item_reg.silent <= silent;
        end
    end

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_read_reg <= (s1_item_reg.func == FUNC_READ);
            ovf_reg      <= ovf_c;
            unf_reg      <= unf_c;
            done_reg     <= done_c;
            slot_reg     <= slot_c;
        end
    end

    // result beat
    assign out_valid      = out_valid_reg;
    assign sample_out     = out_read_reg ? SAMPLE_IO_W'(rdata_reg) : '0;
    assign overflow_seen  = ovf_reg;
    assign underflow_seen = unf_reg;
    assign frame_done     = done_reg;
    assign slot_used      = SLOT_OUT_W'(slot_reg);

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the frame jitter ring: scoreboard, stimulus, handshakes and final check
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fjrr_pkg::*;

    localparam int RING_SLOTS      = 32;
    localparam int RING_FRAME_MAX  = 256;
    localparam int STORE_DEPTH     = RING_SLOTS * RING_FRAME_MAX;
    localparam int HEAVY_IDLE_PCT  = 70;
    localparam int LIGHT_IDLE_PCT  = 18;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 300;
    localparam int NUM_PHASES      = 12;
    localparam int BEATS_PER_PHASE = 120;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one result beat as seen on the output channel
    typedef struct
    {
        logic signed [SAMPLE_IO_W-1:0] sample_val;
        logic                          ovf;
        logic                          unf;
        logic                          done;
        logic [SLOT_OUT_W-1:0]         slot;
    } ring_result_t;

    // ring predictor and queue of predicted result beats
    class ring_scoreboard;
        logic signed [SAMPLE_IO_W-1:0] frame_store [STORE_DEPTH];
        int unsigned slot_count_reg;
        int unsigned frame_len_reg;
        int unsigned wr_slot, rd_slot, wr_off, rd_off;
        int unsigned ovf_mark, unf_mark;
        ring_result_t expected_results [$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < STORE_DEPTH; i++)
                frame_store[i] = '0;
            slot_count_reg = RST_SLOT_COUNT;
            frame_len_reg  = RST_FRAME_LEN;
            wr_slot        = RST_SLOT_COUNT / 2;
            rd_slot        = 0;
            wr_off         = 0;
            rd_off         = 0;
            ovf_mark       = 0;
            unf_mark       = 0;
            mismatches     = 0;
        endfunction

        function int unsigned slot_count_eff();
            if (slot_count_reg < 2)
                return 2;
            if (slot_count_reg > RING_SLOTS)
                return RING_SLOTS;
            return slot_count_reg;
        endfunction

        function int unsigned frame_len_eff();
            if (frame_len_reg < 1)
                return 1;
            if (frame_len_reg > RING_FRAME_MAX)
                return RING_FRAME_MAX;
            return frame_len_reg;
        endfunction

        function void write_register(reg_index_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_SLOT_COUNT)
                slot_count_reg = 32'(value[CFG_SLOT_W-1:0]);
            else
                frame_len_reg = 32'(value[CFG_LEN_W-1:0]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // advance the ring by one accepted input beat and queue its result
        function void note_beat(logic f, logic signed [SAMPLE_IO_W-1:0] s, logic sil);
            int unsigned n;
            int unsigned len;
            int unsigned half;
            ring_result_t r;
            n    = slot_count_eff();
            len  = frame_len_eff();
            half = n / 2;
            r.sample_val = '0;
            r.ovf        = 1'b0;
            r.unf        = 1'b0;
            r.done       = 1'b0;
            r.slot       = '0;

            // stale pointers after a register change restart at zero
            if (wr_slot >= n) wr_slot = 0;
            if (rd_slot >= n) rd_slot = 0;
            if (wr_off >= len) wr_off = 0;
            if (rd_off >= len) rd_off = 0;

            if (f == FUNC_WRITE)
            begin
                // writer caught up with reader: jump half a ring ahead
                if (wr_off == 0 && wr_slot == rd_slot)
                begin
                    if (rd_slot != ovf_mark)
                    begin
                        ovf_mark = rd_slot;
                        r.ovf    = 1'b1;
                    end
                    wr_slot = (rd_slot + half) % n;
                end
                frame_store[wr_slot * RING_FRAME_MAX + wr_off] = sil ? '0 : s;
                r.slot = wr_slot[SLOT_OUT_W-1:0];
                wr_off++;
                if (wr_off >= len)
                begin
                    wr_off  = 0;
                    wr_slot = (wr_slot + 1) % n;
                    r.done  = 1'b1;
                end
            end
            else
            begin
                // reader caught up with writer: drop back half a ring
                if (rd_off == 0 && rd_slot == wr_slot)
                begin
                    if (wr_slot != unf_mark)
                    begin
                        unf_mark = wr_slot;
                        r.unf    = 1'b1;
                    end
                    rd_slot = (wr_slot + n - half) % n;
                end
                r.sample_val = frame_store[rd_slot * RING_FRAME_MAX + rd_off];
                r.slot       = rd_slot[SLOT_OUT_W-1:0];
                rd_off++;
                if (rd_off >= len)
                begin
                    rd_off  = 0;
                    rd_slot = (rd_slot + 1) % n;
                    r.done  = 1'b1;
                end
            end
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic signed [31:0] got_val,
                             logic signed [31:0] want_val);
            $display("%0t mismatch on %s: got %0d, wanted %0d", $time, what, got_val, want_val);
            mismatches++;
        endtask

        // compare one output beat with the oldest prediction
        task check_beat(ring_result_t got);
            ring_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 32'(got.slot), 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.sample_val !== want.sample_val)
                report_mismatch("sample_out", 32'(got.sample_val), 32'(want.sample_val));
            if (got.ovf !== want.ovf)
                report_mismatch("overflow_seen", 32'(got.ovf), 32'(want.ovf));
            if (got.unf !== want.unf)
                report_mismatch("underflow_seen", 32'(got.unf), 32'(want.unf));
            if (got.done !== want.done)
                report_mismatch("frame_done", 32'(got.done), 32'(want.done));
            if (got.slot !== want.slot)
                report_mismatch("slot_used", 32'(got.slot), 32'(want.slot));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [PADDR_W-1:0]            paddr     = '0;
    logic [PDATA_W-1:0]            pwdata    = '0;
    wire  [PDATA_W-1:0]            prdata;
    wire                           pready;
    logic                          in_valid  = 1'b0;
    wire                           in_stall;
    logic                          func      = FUNC_WRITE;
    logic signed [SAMPLE_IO_W-1:0] sample_in = '0;
    logic                          silent    = 1'b0;
    wire                           out_valid;
    logic                          out_stall = 1'b0;
    wire signed [SAMPLE_IO_W-1:0]  sample_out;
    wire                           overflow_seen;
    wire                           underflow_seen;
    wire                           frame_done;
    wire [SLOT_OUT_W-1:0]          slot_used;

    ring_scoreboard sb = new();
    idle_mode_t     idle_mode   = IDLE_NONE;
    int unsigned    hold_cycles = 0;

    frame_jitter_ring_recenter i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .sample_in      (sample_in),
        .silent         (silent),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_out     (sample_out),
        .overflow_seen  (overflow_seen),
        .underflow_seen (underflow_seen),
        .frame_done     (frame_done),
        .slot_used      (slot_used)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            IDLE_BOTH:   return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            IDLE_BOTH:     return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            default:       return 1'b0;
        endcase
    endfunction

    // receiver side: random stalls, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= receiver_stalls();
        end
    end

    // beats accepted on either channel, sampled at the edge
    always @(posedge clk)
    begin
        ring_result_t got;
        if (rst_n && in_valid && !in_stall)
            sb.note_beat(func, sample_in, silent);
        if (rst_n && out_valid && !out_stall)
        begin
            got.sample_val = sample_out;
            got.ovf        = overflow_seen;
            got.unf        = underflow_seen;
            got.done       = frame_done;
            got.slot       = slot_used;
            sb.check_beat(got);
        end
    end

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input reg_index_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.write_register(idx, value);
    endtask

    task automatic configure(input int unsigned slots, input int unsigned len);
        write_reg(REG_SLOT_COUNT, slots);
        write_reg(REG_FRAME_LENGTH, len);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one input beat, with optional idle cycles in front of it
    task automatic offer_beat(input logic f, input logic signed [SAMPLE_IO_W-1:0] s,
                              input logic sil);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        sample_in <= s;
        silent    <= sil;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // stop offering and wait for every predicted result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [SAMPLE_IO_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return -16'sd1;
            default: return SAMPLE_IO_W'($urandom);
        endcase
    endfunction

    // bursts of one direction with a little noise, so the ring laps and recenters
    task automatic run_phase(input int unsigned count, input bit pause_midway);
        int unsigned sent;
        int unsigned burst;
        logic        burst_func;
        logic        f;
        sent = 0;
        while (sent < count)
        begin
            burst_func = 1'($urandom_range(0, 1));
            burst      = $urandom_range(1, 3 * sb.frame_len_eff());
            for (int k = 0; k < burst && sent < count; k++)
            begin
                if (pause_midway && sent == count / 2)
                    drain_results();
                f = ($urandom_range(0, 9) == 0) ? ~burst_func : burst_func;
                offer_beat(f, random_sample(), $urandom_range(0, 4) == 0);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        static int unsigned phase_slots [NUM_PHASES] = '{2, 3, 4, 32, 0, 1, 63, 5, 7, 6, 16, 2};
        static int unsigned phase_len   [NUM_PHASES] = '{1, 2, 4, 3, 1, 5, 2, 0, 511, 257, 8, 3};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, extreme samples, silent sample, read of cleared store
        offer_beat(FUNC_READ, 16'sh1234, 1'b1);
        offer_beat(FUNC_WRITE, 16'sh7fff, 1'b0);
        offer_beat(FUNC_WRITE, 16'sh8000, 1'b0);
        offer_beat(FUNC_WRITE, 16'sh5a5a, 1'b1);
        offer_beat(FUNC_WRITE, 16'sh0000, 1'b0);
        offer_beat(FUNC_WRITE, -16'sd1, 1'b0);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // directed: smallest ring and frame, stale pointers, overflow and underflow
        configure(2, 1);
        offer_beat(FUNC_WRITE, 16'sh0001, 1'b0);
        offer_beat(FUNC_WRITE, 16'sh8000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_WRITE, 16'sh7fff, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_WRITE, -16'sd1, 1'b0);
        offer_beat(FUNC_WRITE, 16'sh4321, 1'b1);
        offer_beat(FUNC_WRITE, 16'sh0002, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);
        offer_beat(FUNC_READ, 16'sh0000, 1'b0);

        // random phases over several ring settings and idle patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            configure(phase_slots[p], phase_len[p]);
            idle_mode = idle_mode_t'(p % 4);
            if (p == 0)
                hold_cycles = LONG_HOLD;
            run_phase(BEATS_PER_PHASE, p == 5);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
